### design/lrc_pkg.sv
// ----------------------------------------------------------------------------
// Log ring package
// Shared widths, operation and status codes and the controller state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrc_pkg;

  // Field widths fixed by the item format.
  localparam int CNT_W    = 64;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 8;
  localparam int COPIED_W = 7;

  // Operation codes.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Read sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLDEST,
    ST_CLAMP,
    ST_AVAIL,
    ST_LEN,
    ST_SUM,
    ST_READ
  } lrc_state_t;

endpackage

### design/lrc_mem.sv
// ----------------------------------------------------------------------------
// Log ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lrc_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lrc_pkg::BYTE_W-1:0] rd_data
);
  import lrc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/lrc_ctrl.sv
// ----------------------------------------------------------------------------
// Log ring read controller
// Clamps the read cursor against the ring window, sizes the burst and
// streams the bytes out of the memory one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_ctrl #(
  parameter int LOG_SIZE  = 16384,
  parameter int MAX_BURST = 64,
  parameter int AW        = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        op,
  input  logic [lrc_pkg::CNT_W-1:0]    read_cursor,
  input  logic signed [lrc_pkg::LEN_W-1:0] max_len,
  input  logic [lrc_pkg::CNT_W-1:0]    wr_count,
  input  logic [AW-1:0]               wr_slot,
  output logic                        busy,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  output logic                        strobe,
  output logic                        byte_valid,
  output logic                        last,
  output logic [lrc_pkg::CNT_W-1:0]    next_cursor,
  output logic [lrc_pkg::CNT_W-1:0]    lost_count,
  output logic [lrc_pkg::COPIED_W-1:0] copied_count,
  output logic                        status
);
  import lrc_pkg::*;

  localparam int SW = AW + 1;
  localparam int CW = (SW > LEN_W) ? SW : LEN_W;
  localparam logic [SW-1:0] SIZE_S = SW'(LOG_SIZE);
  localparam logic [AW-1:0] SLOT_MAX = AW'(LOG_SIZE - 1);

  lrc_state_t state, state_next;

  logic [CNT_W-1:0]    cur;
  logic [CNT_W-1:0]    oldest;
  logic                full;
  logic [SW-1:0]       avail;
  logic [LEN_W-2:0]    len;
  logic [COPIED_W-1:0] remain;
  logic [AW-1:0]       slot;

  logic accept_rd;
  logic neg_len;
  logic emit_empty;
  logic issue_last;

  logic [CNT_W:0]  old_diff;
  logic [CNT_W:0]  clamp_diff;
  logic [CNT_W:0]  avail_diff;
  logic [CW-1:0]   min_a;
  logic [CW-1:0]   min_b;
  logic [SW-1:0]   wslot_s;
  logic [SW-1:0]   start_s;

  assign neg_len   = max_len[LEN_W-1];
  assign accept_rd = start && !busy && (op == OP_READ);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept_rd && !neg_len) state_next = ST_OLDEST;
      ST_OLDEST: state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_AVAIL;
      ST_AVAIL:  state_next = ST_LEN;
      ST_LEN:    state_next = ST_SUM;
      ST_SUM:    state_next = (copied_count == '0) ? ST_IDLE : ST_READ;
      ST_READ:   if (remain == COPIED_W'(1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = 1'b1;
    rd_en      = 1'b0;
    emit_empty = 1'b0;
    issue_last = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_SUM:  emit_empty = (copied_count == '0);
      ST_READ: begin
        rd_en      = 1'b1;
        issue_last = (remain == COPIED_W'(1));
      end
      default: busy = 1'b1;
    endcase
  end

  assign rd_addr = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Wide arithmetic, one operation per step.
  assign old_diff   = {1'b0, wr_count} - {1'b0, CNT_W'(LOG_SIZE)};
  assign clamp_diff = {1'b0, oldest} - {1'b0, cur};
  assign avail_diff = {1'b0, wr_count} - {1'b0, cur};

  // Burst length: the least of what is held, what is asked and the cap.
  assign min_a   = (CW'(avail) < CW'(len)) ? CW'(avail) : CW'(len);
  assign min_b   = (min_a < CW'(MAX_BURST)) ? min_a : CW'(MAX_BURST);
  assign wslot_s = {1'b0, wr_slot};
  assign start_s = (avail > wslot_s) ? (wslot_s + SIZE_S - avail) : (wslot_s - avail);

  // Cursor datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept_rd) begin
          cur        <= read_cursor;
          len        <= max_len[LEN_W-2:0];
          lost_count <= '0;
          status     <= neg_len ? STATUS_ERR : STATUS_OK;
          if (neg_len) begin
            next_cursor  <= read_cursor;
            copied_count <= '0;
          end
        end
      end
      ST_OLDEST: begin
        oldest <= old_diff[CNT_W-1:0];
        full   <= !old_diff[CNT_W] && (old_diff[CNT_W-1:0] != '0);
      end
      ST_CLAMP: begin
        if (full && !clamp_diff[CNT_W] && (clamp_diff[CNT_W-1:0] != '0)) begin
          lost_count <= clamp_diff[CNT_W-1:0];
          cur        <= oldest;
        end
      end
      ST_AVAIL: begin
        if (avail_diff[CNT_W]) begin
          cur   <= wr_count;
          avail <= '0;
        end else begin
          avail <= avail_diff[SW-1:0];
        end
      end
      ST_LEN: begin
        copied_count <= COPIED_W'(min_b);
        remain       <= COPIED_W'(min_b);
        slot         <= start_s[AW-1:0];
      end
      ST_SUM: begin
        next_cursor <= cur + CNT_W'(copied_count);
      end
      ST_READ: begin
        remain <= remain - COPIED_W'(1);
        slot   <= (slot == SLOT_MAX) ? '0 : slot + AW'(1);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // Result strobe and markers, aligned with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      byte_valid <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe     <= rd_en || emit_empty || (accept_rd && neg_len);
      byte_valid <= rd_en;
      last       <= issue_last || emit_empty || (accept_rd && neg_len);
    end
  end

`ifndef SYNTHESIS
  // An empty or error result always closes its read.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !byte_valid |-> last)
    else $error("empty result without last");

  // Every memory read turns into a byte transfer on the next cycle.
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> strobe && byte_valid)
    else $error("memory read not delivered");

  // A byte transfer carries an ok status and a non-zero count.
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && byte_valid |-> (status == STATUS_OK) && (copied_count != '0))
    else $error("byte transfer with bad status or count");

  // A well-formed read makes the block busy on the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    accept_rd && !neg_len |=> busy)
    else $error("read accepted without going busy");
`endif

endmodule

### design/log_ring_with_read_cursor_unit.sv
// ----------------------------------------------------------------------------
// Log ring with read cursor
// Overwriting byte log with a 64-bit count of bytes written and a
// cursor-based burst read port.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   op = append stores write_byte in the ring; busy stays low, so appends
//   may follow every cycle.
//   op = read clamps read_cursor to the held window and returns up to
//   max_len bytes (capped at MAX_BURST), one result per cycle, each marked
//   by strobe for exactly one cycle; last flags the final one.
//   A negative max_len gives a single error result on the next cycle,
//   and busy stays low.
//   Otherwise five cursor steps (oldest, clamp, available, length, end
//   cursor), each one wide add, run before the stream; the first byte
//   read is issued after the end cursor step, and the read holds busy
//   through the steps and its byte reads (an empty read gives one
//   registered result from the end cursor step). The stream itself runs
//   at one byte per cycle, set by the single memory read port.
//   The receiver cannot stall: results are shown once and must be taken.
//   Reset clears the byte count and the controller; ring contents are
//   not cleared, as a read only reaches written bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_ring_with_read_cursor_unit #(
  parameter int LOG_SIZE  = 16384,
  parameter int MAX_BURST = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [lrc_pkg::BYTE_W-1:0]       write_byte,
  input  logic [lrc_pkg::CNT_W-1:0]        read_cursor,
  input  logic signed [lrc_pkg::LEN_W-1:0] max_len,
  output logic                            strobe,
  output logic [lrc_pkg::BYTE_W-1:0]       read_byte,
  output logic                            byte_valid,
  output logic                            last,
  output logic [lrc_pkg::CNT_W-1:0]        next_cursor,
  output logic [lrc_pkg::CNT_W-1:0]        lost_count,
  output logic [lrc_pkg::COPIED_W-1:0]     copied_count,
  output logic                            status
);
  import lrc_pkg::*;

  localparam int AW = (LOG_SIZE > 1) ? $clog2(LOG_SIZE) : 1;
  localparam logic [AW-1:0] SLOT_MAX = AW'(LOG_SIZE - 1);

  logic [CNT_W-1:0]  write_count;
  logic [AW-1:0]     wr_slot;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // An append transfer writes the ring at the current slot.
  assign wr_en = start && !busy && (op == OP_APPEND);

  // Byte count and write slot, which wraps at the ring size.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      wr_slot     <= '0;
    end else if (wr_en) begin
      write_count <= write_count + CNT_W'(1);
      wr_slot     <= (wr_slot == SLOT_MAX) ? '0 : wr_slot + AW'(1);
    end
  end

  lrc_mem #(
    .DEPTH (LOG_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (write_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lrc_ctrl #(
    .LOG_SIZE  (LOG_SIZE),
    .MAX_BURST (MAX_BURST),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .read_cursor  (read_cursor),
    .max_len      (max_len),
    .wr_count     (write_count),
    .wr_slot      (wr_slot),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .strobe       (strobe),
    .byte_valid   (byte_valid),
    .last         (last),
    .next_cursor  (next_cursor),
    .lost_count   (lost_count),
    .copied_count (copied_count),
    .status       (status)
  );

  // Empty and error results carry a zero byte.
  assign read_byte = byte_valid ? rd_data : '0;

endmodule

### sim/tb_log_ring_with_read_cursor_unit.sv
// ----------------------------------------------------------------------------
// Log ring with read cursor: self-checking testbench
// Drives appends and cursor reads through the start/busy port. A behavioural
// mirror of the ring and its byte count predicts every result transfer, and
// each strobed result is checked field by field against the oldest
// prediction. A short table of directed items comes first. Random traffic
// follows, with reads aimed at the held bytes, at the count and far beyond
// it, and with long bursts once enough bytes are held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_log_ring_with_read_cursor_unit;
  import lrc_pkg::*;

  localparam int RING_DEPTH = 16384;
  localparam int BURST_CAP  = 64;

  // One result transfer as the block shows it.
  typedef struct {
    logic [BYTE_W-1:0]   data;
    logic                valid;
    logic                tail;
    logic [CNT_W-1:0]    next_pos;
    logic [CNT_W-1:0]    lost;
    logic [COPIED_W-1:0] copied;
    logic                stat;
  } read_beat_t;

  // One row of the directed table; typed rows carry their single result.
  typedef struct {
    logic                    op;
    logic [BYTE_W-1:0]       data;
    logic [CNT_W-1:0]        cursor;
    logic signed [LEN_W-1:0] limit;
    bit                      typed;
    logic [CNT_W-1:0]        want_next;
    logic                    want_stat;
  } probe_t;

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    start       = 1'b0;
  logic                    busy;
  logic                    op          = OP_APPEND;
  logic [BYTE_W-1:0]       write_byte  = '0;
  logic [CNT_W-1:0]        read_cursor = '0;
  logic signed [LEN_W-1:0] max_len     = '0;
  logic                    strobe;
  logic [BYTE_W-1:0]       read_byte;
  logic                    byte_valid;
  logic                    last;
  logic [CNT_W-1:0]        next_cursor;
  logic [CNT_W-1:0]        lost_count;
  logic [COPIED_W-1:0]     copied_count;
  logic                    status;

  // Mirror of the ring contents and of the count of bytes ever appended.
  logic [BYTE_W-1:0] ring_mirror [RING_DEPTH];
  logic [CNT_W-1:0]  byte_total = '0;
  read_beat_t        due_beats [$];

  int fail_count     = 0;
  int appends_taken  = 0;
  int reads_taken    = 0;
  int lossy_reads    = 0;
  int rejected_reads = 0;
  int beats_checked  = 0;

  log_ring_with_read_cursor_unit #(
    .LOG_SIZE (RING_DEPTH),
    .MAX_BURST(BURST_CAP)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .write_byte  (write_byte),
    .read_cursor (read_cursor),
    .max_len     (max_len),
    .strobe      (strobe),
    .read_byte   (read_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .next_cursor (next_cursor),
    .lost_count  (lost_count),
    .copied_count(copied_count),
    .status      (status)
  );

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net against a hung handshake or a missing result.
  initial begin
    #2_000_000;
    $error("Run timed out with %0d results still outstanding", due_beats.size());
    $display("Test completed with failures");
    $finish;
  end

  // An append lands in slot count mod depth and bumps the count.
  function automatic void mirror_append(input logic [BYTE_W-1:0] b);
    ring_mirror[byte_total % RING_DEPTH] = b;
    byte_total = byte_total + 1;
    appends_taken++;
  endfunction

  // Works out every result transfer that one read causes and queues them.
  function automatic void predict_read(input logic [CNT_W-1:0] cursor,
                                       input logic signed [LEN_W-1:0] limit);
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] want;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
    read_beat_t       beat;
    reads_taken++;
    beat.data     = '0;
    beat.valid    = 1'b0;
    beat.tail     = 1'b1;
    beat.next_pos = cursor;
    beat.lost     = '0;
    beat.copied   = '0;
    beat.stat     = STATUS_ERR;
    // A negative length is refused and leaves the cursor untouched.
    if (limit[LEN_W-1]) begin
      rejected_reads++;
      due_beats.push_back(beat);
      return;
    end
    // Pull the cursor into the held window, counting what was overwritten.
    cur  = cursor;
    lost = '0;
    if (byte_total > RING_DEPTH && cur < byte_total - RING_DEPTH) begin
      lost = byte_total - RING_DEPTH - cur;
      cur  = byte_total - RING_DEPTH;
    end
    if (cur > byte_total) cur = byte_total;
    if (lost != 0) lossy_reads++;
    // Bytes returned: what is available, the request and the burst cap.
    want = {{(CNT_W-LEN_W){1'b0}}, limit};
    n    = byte_total - cur;
    if (n > want) n = want;
    if (n > BURST_CAP) n = BURST_CAP;
    beat.stat     = STATUS_OK;
    beat.lost     = lost;
    beat.next_pos = cur + n;
    beat.copied   = n[COPIED_W-1:0];
    if (n == 0) begin
      due_beats.push_back(beat);
      return;
    end
    for (k = 0; k < n; k++) begin
      beat.valid = 1'b1;
      beat.tail  = (k + 1 == n);
      beat.data  = ring_mirror[(cur + k) % RING_DEPTH];
      due_beats.push_back(beat);
    end
  endfunction

  function automatic probe_t step_row(input logic kind, input logic [BYTE_W-1:0] data,
                                      input logic [CNT_W-1:0] cursor,
                                      input logic signed [LEN_W-1:0] limit);
    probe_t r;
    r.op        = kind;
    r.data      = data;
    r.cursor    = cursor;
    r.limit     = limit;
    r.typed     = 1'b0;
    r.want_next = '0;
    r.want_stat = STATUS_OK;
    return r;
  endfunction

  // A read whose single result is known outright: empty or refused.
  function automatic probe_t fixed_row(input logic [CNT_W-1:0] cursor,
                                       input logic signed [LEN_W-1:0] limit,
                                       input logic [CNT_W-1:0] want_next,
                                       input logic want_stat);
    probe_t r;
    r           = step_row(OP_READ, '0, cursor, limit);
    r.typed     = 1'b1;
    r.want_next = want_next;
    r.want_stat = want_stat;
    return r;
  endfunction

  // Presents one item and holds it until the block takes the transfer.
  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data,
                           input logic [CNT_W-1:0] cursor,
                           input logic signed [LEN_W-1:0] limit);
    start       <= 1'b1;
    op          <= kind;
    write_byte  <= data;
    read_cursor <= cursor;
    max_len     <= limit;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic issue_read(input logic [CNT_W-1:0] cursor,
                            input logic signed [LEN_W-1:0] limit);
    send_item(OP_READ, BYTE_W'($urandom), cursor, limit);
    predict_read(cursor, limit);
  endtask

  // Now and then the sender goes quiet for a short burst.
  task automatic pause_sender(input bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // One random item; reads mostly aim at the held window and its edges.
  task automatic random_item(input int append_pct, input bit quiet);
    logic [CNT_W-1:0]        cursor;
    logic signed [LEN_W-1:0] limit;
    logic [BYTE_W-1:0]       data;
    int unsigned             held;
    held   = (byte_total > RING_DEPTH) ? RING_DEPTH : 32'(byte_total);
    cursor = {$urandom, $urandom};
    limit  = LEN_W'($urandom);
    data   = BYTE_W'($urandom);
    if ($urandom_range(1, 100) <= append_pct) begin
      send_item(OP_APPEND, data, cursor, limit);
      mirror_append(data);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: cursor = byte_total - $urandom_range(0, held);
        // Behind the window; wraps to a huge cursor while the ring is young.
        5:       cursor = byte_total - held - $urandom_range(1, 2000);
        6:       cursor = byte_total - held;
        7:       cursor = byte_total + $urandom_range(0, 300);
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       limit = {1'b1, 7'($urandom)};
        1:       limit = '0;
        2:       limit = LEN_W'($urandom_range(BURST_CAP, 127));
        default: limit = LEN_W'($urandom_range(1, BURST_CAP));
      endcase
      issue_read(cursor, limit);
    end
    pause_sender(quiet);
  endtask

  // Checks one field of a result transfer.
  task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin : result_watch
    read_beat_t want;
    if (!rst && strobe === 1'b1) begin
      if (due_beats.size() == 0) begin
        $error("Result transfer with no read outstanding: next_cursor %0h", next_cursor);
        fail_count++;
      end else begin
        want = due_beats.pop_front();
        beats_checked++;
        compare_field("read_byte", want.data, read_byte);
        compare_field("byte_valid", want.valid, byte_valid);
        compare_field("last", want.tail, last);
        compare_field("next_cursor", want.next_pos, next_cursor);
        compare_field("lost_count", want.lost, lost_count);
        compare_field("copied_count", want.copied, copied_count);
        compare_field("status", want.stat, status);
      end
    end
  end

  initial begin : stimulus
    probe_t            plan [$];
    read_beat_t        fixed;

    // Empty ring: in-range, far-off and refused reads, then a few appends.
    plan.push_back(fixed_row(64'd0, 8'sd10, 64'd0, STATUS_OK));
    plan.push_back(fixed_row({CNT_W{1'b1}}, 8'sd64, 64'd0, STATUS_OK));
    plan.push_back(fixed_row(64'h0123_4567_89AB_CDEF, -8'sd1, 64'h0123_4567_89AB_CDEF,
                             STATUS_ERR));
    plan.push_back(fixed_row({CNT_W{1'b1}}, -8'sd128, {CNT_W{1'b1}}, STATUS_ERR));
    plan.push_back(step_row(OP_APPEND, 8'h00, {CNT_W{1'b1}}, -8'sd1));
    plan.push_back(step_row(OP_APPEND, 8'hFF, 64'd0, 8'sd0));
    plan.push_back(step_row(OP_APPEND, 8'hA5, 64'd3, 8'sd5));
    plan.push_back(step_row(OP_APPEND, 8'h5A, 64'd0, 8'sd127));
    plan.push_back(step_row(OP_APPEND, 8'h01, 64'd9, -8'sd64));
    plan.push_back(step_row(OP_APPEND, 8'h80, 64'd0, 8'sd1));
    // Six bytes held: zero length, cursor at and past the count, capped ask, short reads, a refused one.
    plan.push_back(fixed_row(64'd0, 8'sd0, 64'd0, STATUS_OK));
    plan.push_back(step_row(OP_READ, 8'h00, 64'd0, 8'sd127));
    plan.push_back(fixed_row(64'd6, 8'sd5, 64'd6, STATUS_OK));
    plan.push_back(fixed_row({CNT_W{1'b1}}, 8'sd1, 64'd6, STATUS_OK));
    plan.push_back(fixed_row(64'h8000_0000_0000_0000, 8'sd64, 64'd6, STATUS_OK));
    plan.push_back(step_row(OP_READ, 8'h00, 64'd2, 8'sd2));
    plan.push_back(step_row(OP_READ, 8'h00, 64'd5, 8'sd64));
    plan.push_back(step_row(OP_READ, 8'h00, 64'd0, 8'sd1));
    plan.push_back(fixed_row(64'd0, -8'sd64, 64'd0, STATUS_ERR));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (plan[i]) begin
      send_item(plan[i].op, plan[i].data, plan[i].cursor, plan[i].limit);
      if (plan[i].op == OP_APPEND) begin
        mirror_append(plan[i].data);
      end else if (!plan[i].typed) begin
        predict_read(plan[i].cursor, plan[i].limit);
      end else begin
        reads_taken++;
        if (plan[i].want_stat == STATUS_ERR) rejected_reads++;
        fixed.data     = '0;
        fixed.valid    = 1'b0;
        fixed.tail     = 1'b1;
        fixed.next_pos = plan[i].want_next;
        fixed.lost     = '0;
        fixed.copied   = '0;
        fixed.stat     = plan[i].want_stat;
        due_beats.push_back(fixed);
      end
      pause_sender(1'b0);
    end

    // Young ring: append-heavy traffic, with stretches sent without pauses.
    for (int n = 0; n < 140; n++) random_item(60, (n % 50) >= 38);

    // Hold off until every outstanding result has been seen.
    start <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);

    // Reads at the start of the log, two cursors that wrap far past the count, and one near the end.
    issue_read(64'd0, 8'sd64);
    issue_read(byte_total - RING_DEPTH - 1, 8'sd3);
    issue_read(byte_total - RING_DEPTH, 8'sd64);
    issue_read(byte_total - 1, 8'sd64);
    for (int n = 0; n < 160; n++) random_item(40, n >= 100);

    // Drain, then allow for the read pipeline before closing.
    start <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);
    repeat (16) @(posedge clk);

    $display("Covered %0d appends and %0d reads (%0d behind the held window, %0d refused).",
             appends_taken, reads_taken, lossy_reads, rejected_reads);
    $display("Checked %0d result transfers; the byte count reached %0d.",
             beats_checked, byte_total);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
